### design/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  // Default sizing of the block table and of the per-block header.
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 24;

  // Field widths fixed by the interface.
  localparam int DATA_W    = 32;
  localparam int SLOT_W    = 6;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;
  localparam logic [DATA_W-1:0]    HEAP_BASE_RST  = 32'd4096;
  localparam logic [DATA_W-1:0]    HEAP_LIMIT_RST = 32'd1048576;

  // Request modes. Any other code is handled as a release.
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_CALLOC = 2'd1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HEAP    = 3'd1,
    ST_TABLE   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_NULL    = 3'd4
  } status_t;

  // One row of the block table.
  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] length;
    logic              is_free;
  } entry_t;

  // Finished result handed from the sequencer to the output stage.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] addr;
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

`default_nettype wire

### design/ffba_table.sv
`default_nettype none

module ffba_table #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0] waddr,
  input  wire ffba_pkg::entry_t              wdata,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0] raddr,
  output ffba_pkg::entry_t                   rdata
);
  import ffba_pkg::*;

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_r;

  // Single write port; contents are never cleared since only filled rows are read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [31:0]                   in_request_size,
  input  wire logic [31:0]                   in_element_count,
  input  wire logic [31:0]                   in_release_address,
  input  wire logic [31:0]                   heap_base,
  input  wire logic [31:0]                   heap_limit,
  output ffba_pkg::result_t                  res,
  input  wire logic                          res_taken,
  output logic [$clog2(MAX_BLOCKS)-1:0]      mem_raddr,
  input  wire ffba_pkg::entry_t              mem_rdata,
  output logic                               mem_we,
  output logic [$clog2(MAX_BLOCKS)-1:0]      mem_waddr,
  output ffba_pkg::entry_t                   mem_wdata
);
  import ffba_pkg::*;

  localparam int SW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = SW + SLOT_W;
  localparam logic [DATA_W-1:0] HDR = DATA_W'(HEADER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULCHK,
    S_START,
    S_SCAN,
    S_NOMATCH,
    S_DONE
  } state_t;

  state_t            state_r;
  logic              op_free_r;
  logic [DATA_W-1:0] req_r;
  logic [DATA_W-1:0] rel_r;
  logic [63:0]       prod_r;
  logic [SW-1:0]     idx_r;
  logic [CW-1:0]     count_r;
  logic [DATA_W-1:0] heap_used_r;
  logic [DATA_W-1:0] res_addr_r;
  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;

  logic [DATA_W-1:0] payload;
  logic              hit;
  logic              last;
  logic              table_full;
  logic [33:0]       need;
  logic              need_over;
  logic [EW-1:0]     idx_wide;
  logic [EW-1:0]     cnt_wide;
  logic [SW-1:0]     app_idx;

  // Compare the row read last cycle against the pending request.
  assign payload = heap_base + mem_rdata.start + HDR;
  assign hit     = op_free_r ? (payload == rel_r)
                             : (mem_rdata.is_free && (mem_rdata.length >= req_r));
  assign last    = (CW'(idx_r) + CW'(1)) == count_r;

  // Room checks for appending a new block at the heap top.
  assign table_full = (count_r == CW'(MAX_BLOCKS));
  assign need       = {2'b00, heap_used_r} + {2'b00, req_r} + {2'b00, HDR};
  assign need_over  = (need > {2'b00, heap_limit});
  assign app_idx    = count_r[SW-1:0];

  // Slot numbers are reported in a fixed six-bit field.
  assign idx_wide = EW'(idx_r);
  assign cnt_wide = EW'(app_idx);

  // Next row to read: the scan runs one row per cycle from row zero.
  always_comb begin
    if (state_r == S_SCAN && !last) begin
      mem_raddr = idx_r + SW'(1);
    end else begin
      mem_raddr = '0;
    end
  end

  // Write back a row on a hit, or for an allocation append a row when nothing fits and there is room.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = mem_rdata;
    if (state_r == S_SCAN && hit) begin
      mem_we            = 1'b1;
      mem_wdata.is_free = op_free_r;
    end else if (state_r == S_NOMATCH && !op_free_r && !table_full && !need_over) begin
      mem_we    = 1'b1;
      mem_waddr = app_idx;
      mem_wdata = '{start: heap_used_r, length: req_r, is_free: 1'b0};
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign res      = '{valid: (state_r == S_DONE), addr: res_addr_r,
                      status: res_status_r, slot: res_slot_r};

  // Sequencer: one request at a time, table scan, then result hand-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      heap_used_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_free_r <= (in_mode != MODE_ALLOC) && (in_mode != MODE_CALLOC);
            req_r     <= in_request_size;
            rel_r     <= in_release_address;
            prod_r    <= 64'(in_element_count) * 64'(in_request_size);
            state_r   <= (in_mode == MODE_CALLOC) ? S_MULCHK : S_START;
          end
        end
        S_MULCHK: begin
          if (prod_r[63:32] != '0) begin
            res_addr_r   <= '0;
            res_status_r <= ST_HEAP;
            res_slot_r   <= '0;
            state_r      <= S_DONE;
          end else begin
            req_r   <= prod_r[31:0];
            state_r <= S_START;
          end
        end
        S_START: begin
          idx_r <= '0;
          priority if (op_free_r && rel_r == '0) begin
            res_addr_r   <= '0;
            res_status_r <= ST_NULL;
            res_slot_r   <= '0;
            state_r      <= S_DONE;
          end else if (count_r == '0) begin
            state_r <= S_NOMATCH;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_addr_r   <= op_free_r ? '0 : payload;
            res_status_r <= ST_OK;
            res_slot_r   <= idx_wide[SLOT_W-1:0];
            state_r      <= S_DONE;
          end else if (last) begin
            state_r <= S_NOMATCH;
          end else begin
            idx_r <= idx_r + SW'(1);
          end
        end
        S_NOMATCH: begin
          res_addr_r <= '0;
          res_slot_r <= '0;
          priority if (op_free_r) begin
            res_status_r <= ST_UNKNOWN;
          end else if (table_full) begin
            res_status_r <= ST_TABLE;
          end else if (need_over) begin
            res_status_r <= ST_HEAP;
          end else begin
            res_addr_r   <= heap_base + heap_used_r + HDR;
            res_status_r <= ST_OK;
            res_slot_r   <= cnt_wide[SLOT_W-1:0];
            heap_used_r  <= need[DATA_W-1:0];
            count_r      <= count_r + CW'(1);
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_taken) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/first_fit_block_allocator.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   mode, request_size, element_count, release_address
// out_     output     out_valid/out_stall granted_address, status, block_slot
// cfg_     input      cfg_we              cfg_index, cfg_wdata (heap_base, heap_limit)
//
// One request is handled at a time. A request passes through a start step, the table
// scan, a no-match step when needed and a result step, plus a product check for a zeroed
// allocate; the table scan reads one row per cycle from the block table.
// Reset clears the block count and heap usage; the table is not cleared.
// A result waits in the output register under out_stall while the next request is taken.
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_mode,
  input  wire logic [31:0]                        in_request_size,
  input  wire logic [31:0]                        in_element_count,
  input  wire logic [31:0]                        in_release_address,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [31:0]                             out_granted_address,
  output logic [2:0]                              out_status,
  output logic [5:0]                              out_block_slot,
  input  wire logic                               cfg_we,
  input  wire logic [ffba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ffba_pkg::DATA_W-1:0]        cfg_wdata
);
  import ffba_pkg::*;

  localparam int SW = $clog2(MAX_BLOCKS);

  logic [DATA_W-1:0] heap_base_r;
  logic [DATA_W-1:0] heap_limit_r;
  result_t           res;
  logic              res_taken;
  logic [SW-1:0]     mem_raddr;
  entry_t            mem_rdata;
  logic              mem_we;
  logic [SW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_addr_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= HEAP_BASE_RST;
      heap_limit_r <= HEAP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAP_BASE:  heap_base_r  <= cfg_wdata;
        CFG_HEAP_LIMIT: heap_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ffba_table #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ffba_ctrl #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_request_size   (in_request_size),
    .in_element_count  (in_element_count),
    .in_release_address(in_release_address),
    .heap_base         (heap_base_r),
    .heap_limit        (heap_limit_r),
    .res               (res),
    .res_taken         (res_taken),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata)
  );

  // Output register: loads when empty or when its current transfer completes.
  assign res_taken = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_taken) begin
      out_valid_r  <= 1'b1;
      out_addr_r   <= res.addr;
      out_status_r <= res.status;
      out_slot_r   <= res.slot;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = 3'(out_status_r);
  assign out_block_slot      = out_slot_r;

endmodule

`default_nettype wire

### sim/ffba_allocation_checker.sv
module ffba_allocation_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [31:0]                    in_request_size,
  input  logic [31:0]                    in_element_count,
  input  logic [31:0]                    in_release_address,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [31:0]                    out_granted_address,
  input  logic [2:0]                     out_status,
  input  logic [5:0]                     out_block_slot,
  input  logic                           cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  output int                             fail_count,
  output int                             pending_count
);
  import ffba_pkg::*;

  localparam int SLOTS  = MAX_BLOCKS_DEF;
  localparam int HEADER = HEADER_BYTES_DEF;

  typedef struct {
    logic [31:0] addr;
    status_t     status;
    logic [5:0]  slot;
  } reply_t;

  // Shadow copy of the registers and of the block table.
  logic [31:0] heap_base;
  logic [31:0] heap_limit;
  logic [31:0] heap_used;
  logic [31:0] blk_start [SLOTS];
  logic [31:0] blk_length [SLOTS];
  logic        blk_free [SLOTS];
  int          blk_count;
  reply_t      replies_due [$];

  // Payload address of a table row under the current base, wrapping at 32 bits.
  function automatic logic [31:0] payload_of(int idx);
    return heap_base + blk_start[idx] + 32'(HEADER);
  endfunction

  // First-fit search; on a miss, append a new row at the top of the heap if the table and heap have room.
  function automatic reply_t claim_block(logic [31:0] req);
    reply_t      r;
    logic [33:0] need;
    r.addr   = '0;
    r.status = ST_OK;
    r.slot   = '0;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_length[i] >= req) begin
        blk_free[i] = 1'b0;
        r.addr      = payload_of(i);
        r.slot      = 6'(i);
        return r;
      end
    end
    if (blk_count >= SLOTS) begin
      r.status = ST_TABLE;
      return r;
    end
    need = {2'b00, heap_used} + {2'b00, req} + 34'(HEADER);
    if (need > {2'b00, heap_limit}) begin
      r.status = ST_HEAP;
      return r;
    end
    blk_start[blk_count]  = heap_used;
    blk_length[blk_count] = req;
    blk_free[blk_count]   = 1'b0;
    heap_used             = need[31:0];
    r.addr                = payload_of(blk_count);
    r.slot                = 6'(blk_count);
    blk_count++;
    return r;
  endfunction

  // A release marks the lowest row whose payload address matches.
  function automatic reply_t release_block(logic [31:0] addr);
    reply_t r;
    r.addr   = '0;
    r.status = ST_UNKNOWN;
    r.slot   = '0;
    if (addr == '0) begin
      r.status = ST_NULL;
      return r;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (payload_of(i) == addr) begin
        blk_free[i] = 1'b1;
        r.status    = ST_OK;
        r.slot      = 6'(i);
        return r;
      end
    end
    return r;
  endfunction

  function automatic reply_t predict_reply(logic [1:0] mode, logic [31:0] size,
                                           logic [31:0] count, logic [31:0] addr);
    reply_t      r;
    logic [63:0] total;
    total = 64'(count) * 64'(size);
    case (mode)
      MODE_ALLOC: return claim_block(size);
      MODE_CALLOC: begin
        // A product that does not fit in 32 bits fails without touching the table.
        if (total[63:32] != '0) begin
          r.addr   = '0;
          r.status = ST_HEAP;
          r.slot   = '0;
          return r;
        end
        return claim_block(total[31:0]);
      end
      default: return release_block(addr);
    endcase
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each result transfer first, then predict any request transfer.
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      heap_base  = HEAP_BASE_RST;
      heap_limit = HEAP_LIMIT_RST;
      heap_used  = '0;
      blk_count  = 0;
      replies_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          heap_base = cfg_wdata;
        end else begin
          heap_limit = cfg_wdata;
        end
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with no request outstanding: addr %h status %0d slot %0d",
                   $time, out_granted_address, out_status, out_block_slot);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          compare_field("granted_address", want.addr, out_granted_address);
          compare_field("status", 32'(want.status), 32'(out_status));
          compare_field("block_slot", 32'(want.slot), 32'(out_block_slot));
        end
      end
      if (in_valid && !in_stall) begin
        replies_due.push_back(predict_reply(in_mode, in_request_size, in_element_count,
                                            in_release_address));
      end
    end
    pending_count = replies_due.size();
  end

endmodule

### sim/first_fit_block_allocator_tb.sv
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam logic [1:0]  MODE_FREE      = 2'd2;
  localparam logic [1:0]  MODE_SPARE     = 2'd3;
  localparam logic [31:0] FIRST_PAYLOAD  = HEAP_BASE_RST + 32'(HEADER_BYTES_DEF);
  localparam logic [31:0] SECOND_PAYLOAD = FIRST_PAYLOAD + 32'(HEADER_BYTES_DEF);
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 100;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_mode;
  logic [31:0]          in_request_size;
  logic [31:0]          in_element_count;
  logic [31:0]          in_release_address;
  logic                 out_valid;
  logic                 out_stall;
  logic [31:0]          out_granted_address;
  logic [2:0]           out_status;
  logic [5:0]           out_block_slot;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;
  int                   fail_count;
  int                   pending_count;

  logic        in_xfer;
  logic        out_xfer;
  logic        steady;
  logic [31:0] heap_base_now;
  logic [31:0] live_offsets [$];
  int          status_seen [5];
  int          requests_sent;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  first_fit_block_allocator i_dut (.*);

  ffba_allocation_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Track granted blocks as heap offsets so that releases survive a base change.
  always @(posedge clk) begin
    if (out_xfer) begin
      if (out_status <= ST_NULL) status_seen[out_status]++;
      if (out_status == ST_OK && out_granted_address != '0) begin
        live_offsets.push_back(out_granted_address - heap_base_now);
      end
    end
  end

  // Result side backpressure: bursts of stall with occasional quiet stretches.
  initial begin
    int   stall_left;
    int   quiet_left;
    int   pick;
    logic stall_next;
    stall_left = 0;
    quiet_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      stall_next = 1'b0;
      if (steady) begin
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          stall_left = $urandom_range(0, 9);
          stall_next = 1'b1;
        end else if (pick < 25) begin
          quiet_left = $urandom_range(20, 80);
        end
      end
      out_stall <= stall_next;
    end
  end

  // The run ends if neither channel nor the register port moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (in_xfer || out_xfer || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("first_fit_block_allocator_tb: FAIL");
    $finish;
  end

  // One request transfer, preceded by an optional gap on the request side.
  task automatic send_request(logic [1:0] mode, logic [31:0] size, logic [31:0] count,
                              logic [31:0] addr);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode            <= mode;
    in_request_size    <= size;
    in_element_count   <= count;
    in_release_address <= addr;
    in_valid           <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(logic [31:0] base, logic [31:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEAP_BASE;
    cfg_wdata <= base;
    @(negedge clk);
    cfg_index <= CFG_HEAP_LIMIT;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we        <= 1'b0;
    heap_base_now  = base;
  endtask

  // Mostly well-formed traffic: allocations of modest size and releases of live
  // blocks, with a share of malformed or out-of-range requests mixed in.
  task automatic random_request(int alloc_pct);
    int          pick;
    int          idx;
    logic [1:0]  mode;
    logic [31:0] size;
    logic [31:0] count;
    logic [31:0] addr;
    size  = $urandom;
    count = $urandom;
    addr  = $urandom;
    pick  = $urandom_range(0, 99);
    if ($urandom_range(0, 99) == 0) settle();
    if (pick < alloc_pct) begin
      case ($urandom_range(0, 19))
        0:             ;
        1, 2:          size = $urandom_range(0, 65536);
        3, 4, 5, 6, 7: size = $urandom_range(0, 1024);
        default:       size = $urandom_range(0, 64);
      endcase
      send_request(MODE_ALLOC, size, count, addr);
    end else if (pick < alloc_pct + 10) begin
      if ($urandom_range(0, 9) != 0) begin
        count = $urandom_range(0, 16);
        size  = $urandom_range(0, 96);
      end
      send_request(MODE_CALLOC, size, count, addr);
    end else if (pick < 92 && live_offsets.size() != 0) begin
      idx  = $urandom_range(0, live_offsets.size() - 1);
      addr = heap_base_now + live_offsets[idx];
      // Leaving the entry in place now and then produces a later double release.
      if ($urandom_range(0, 9) != 0) live_offsets.delete(idx);
      mode = ($urandom_range(0, 7) == 0) ? MODE_SPARE : MODE_FREE;
      send_request(mode, size, count, addr);
    end else begin
      mode = ($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_FREE;
      case ($urandom_range(0, 3))
        0: send_request(mode, size, count, '0);
        1: send_request(mode, size, count, addr);
        2: send_request(MODE_ALLOC, size, count, addr);
        default: begin
          if (live_offsets.size() != 0) begin
            addr = heap_base_now + live_offsets[0] + 32'($urandom_range(1, 7));
          end
          send_request(mode, size, count, addr);
        end
      endcase
    end
  endtask

  task automatic run_phase(logic [31:0] base, logic [31:0] limit, int items, int alloc_pct);
    settle();
    configure(base, limit);
    repeat (items) random_request(alloc_pct);
  endtask

  initial begin
    int failures;
    in_valid           = 1'b0;
    in_mode            = MODE_ALLOC;
    in_request_size    = '0;
    in_element_count   = '0;
    in_release_address = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_HEAP_BASE;
    cfg_wdata          = '0;
    steady             = 1'b0;
    heap_base_now      = HEAP_BASE_RST;
    requests_sent      = 0;
    rst_n              = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values.
    send_request(MODE_ALLOC, 32'd0, $urandom, $urandom);
    send_request(MODE_ALLOC, 32'd100, $urandom, $urandom);
    send_request(MODE_FREE, $urandom, $urandom, FIRST_PAYLOAD);
    send_request(MODE_FREE, $urandom, $urandom, FIRST_PAYLOAD);
    send_request(MODE_ALLOC, 32'd0, $urandom, $urandom);
    send_request(MODE_FREE, $urandom, $urandom, 32'd0);
    send_request(MODE_FREE, $urandom, $urandom, 32'hFFFF_FFFF);
    send_request(MODE_SPARE, $urandom, $urandom, SECOND_PAYLOAD);
    send_request(MODE_ALLOC, 32'd50, $urandom, $urandom);
    // Zeroed allocations: overflowing products, a product at the 32-bit edge, zero.
    send_request(MODE_CALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
    send_request(MODE_CALLOC, 32'h0001_0000, 32'h0001_0000, $urandom);
    send_request(MODE_CALLOC, 32'h0001_0001, 32'h0000_FFFF, $urandom);
    send_request(MODE_CALLOC, 32'hFFFF_FFFF, 32'd0, $urandom);
    send_request(MODE_CALLOC, 32'd10, 32'd3, $urandom);
    // Heap limit: far beyond it, an exact fit, then a bare header that no longer fits.
    send_request(MODE_ALLOC, 32'hFFFF_FFFF, $urandom, $urandom);
    send_request(MODE_ALLOC, HEAP_LIMIT_RST - 32'd250, $urandom, $urandom);
    send_request(MODE_ALLOC, 32'd0, $urandom, $urandom);
    // Reuse: one byte over the free block's length misses, its exact length fits.
    send_request(MODE_FREE, $urandom, $urandom, SECOND_PAYLOAD);
    send_request(MODE_ALLOC, 32'd101, $urandom, $urandom);
    send_request(MODE_ALLOC, 32'd100, $urandom, $urandom);
    send_request(MODE_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FIRST_PAYLOAD + 32'd226);
    send_request(MODE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);

    // Random part over several register settings, extremes included.
    run_phase(32'd0, 32'd0, 150, 40);
    run_phase(32'hFFFF_FF00, 32'hFFFF_FFFF, 300, 55);
    run_phase(HEAP_BASE_RST, HEAP_LIMIT_RST, 400, 45);
    run_phase($urandom, $urandom, 300, 45);
    settle();
    steady = 1'b1;
    configure(32'h8000_0000, 32'h0010_0000);
    repeat (300) random_request(45);

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    failures = fail_count + pending_count;
    $display("Sent %0d requests across six base and limit settings, with random gaps",
             requests_sent);
    $display("and stalls, then a full-rate stretch: %0d ok, %0d heap, %0d table, %0d %s",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             $sformatf("unknown and %0d null releases.", status_seen[4]));
    if (failures == 0) begin
      $display("first_fit_block_allocator_tb: PASS");
    end else begin
      $display("first_fit_block_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
